@@ rtl/rmd_pkg.sv @@
// Shared types and constants for the record marking deframer.
package rmd_pkg;

   // Field widths
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 31;
   localparam int ID_W   = 32;

   // Marker layout and framing limits
   localparam int            LAST_BIT         = 31;
   localparam logic [LEN_W-1:0] MARKER_BYTES  = 31'd4;
   localparam logic [LEN_W-1:0] ID_BYTES      = 31'd4;
   localparam logic [LEN_W-1:0] MIN_FRAG_LEN  = 31'd4;
   localparam logic [LEN_W-1:0] FIRST_OFFSET  = 31'd4;
   localparam logic [LEN_W-1:0] BUF_RESET     = 31'd65536;

   // Classification of each consumed byte
   typedef enum logic [2:0] {
      KIND_MARKER  = 3'd0,
      KIND_ID      = 3'd1,
      KIND_PAYLOAD = 3'd2,
      KIND_DISCARD = 3'd3,
      KIND_HALTED  = 3'd4
   } kind_type;

   // One result item
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      kind_type          byte_kind;
      logic [LEN_W-1:0]  reply_offset;
      logic [ID_W-1:0]   reply_id;
      logic              reply_done;
      logic [LEN_W-1:0]  reply_length;
      logic              frame_error;
   } result_type;

endpackage

@@ rtl/rpc_record_marking_deframer.sv @@
// Top level of the RPC record marking deframer.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_ready  byte_value
//   rsp_     out        rsp_valid/rsp_ready  out_byte, byte_kind, reply_offset,
//                                            reply_id, reply_done, reply_length,
//                                            frame_error
//   csr_     in         csr_valid/csr_ready  reply_buffer_bytes
//
// One byte per clock sustained while the response side is not stalled; a request
// passes the input register, the decode logic and the result register in turn.
// Reset is synchronous and active high; the buffer size returns to 65536.
// A stalled response holds the result register and the byte behind it;
// req_ready is high while the input register is empty or its byte moves on.
module rpc_record_marking_deframer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [rmd_pkg::BYTE_W-1:0] req_byte_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [rmd_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic [2:0]                 rsp_byte_kind,
   output logic [rmd_pkg::LEN_W-1:0]  rsp_reply_offset,
   output logic [rmd_pkg::ID_W-1:0]   rsp_reply_id,
   output logic                       rsp_reply_done,
   output logic [rmd_pkg::LEN_W-1:0]  rsp_reply_length,
   output logic                       rsp_frame_error,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [rmd_pkg::LEN_W-1:0]  csr_reply_buffer_bytes
);

   logic                       item_valid;
   logic [rmd_pkg::BYTE_W-1:0] item_byte;
   logic                       out_free;
   logic                       fire;
   rmd_pkg::result_type        result;
   rmd_pkg::result_type        rsp_item;

   // A byte moves through decode when held and the result slot is free
   assign fire = item_valid && out_free;

   rmd_in_reg u_in_reg (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_byte_value (req_byte_value),
      .take           (fire),
      .item_valid     (item_valid),
      .item_byte      (item_byte)
   );

   rmd_core u_core (
      .clock                  (clock),
      .reset                  (reset),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_reply_buffer_bytes (csr_reply_buffer_bytes),
      .fire                   (fire),
      .item_byte              (item_byte),
      .result                 (result)
   );

   rmd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // Unpack the result onto the response ports
   assign rsp_out_byte     = rsp_item.out_byte;
   assign rsp_byte_kind    = rsp_item.byte_kind;
   assign rsp_reply_offset = rsp_item.reply_offset;
   assign rsp_reply_id     = rsp_item.reply_id;
   assign rsp_reply_done   = rsp_item.reply_done;
   assign rsp_reply_length = rsp_item.reply_length;
   assign rsp_frame_error  = rsp_item.frame_error;

endmodule

@@ rtl/rmd_in_reg.sv @@
// Input register stage: holds one request byte until the core takes it.
module rmd_in_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [rmd_pkg::BYTE_W-1:0] req_byte_value,
   input  logic                      take,
   output logic                      item_valid,
   output logic [rmd_pkg::BYTE_W-1:0] item_byte
);

   logic                       valid_ff, valid_in;
   logic [rmd_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic                       load;

   // Accept when empty or when the held byte moves on this cycle
   assign req_ready = !valid_ff || take;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in = load || (valid_ff && !take);
      byte_in  = load ? req_byte_value : byte_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

@@ rtl/rmd_core.sv @@
// Deframer state and per-byte decode: marker, id, payload, discard, halt.
module rmd_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [rmd_pkg::LEN_W-1:0]  csr_reply_buffer_bytes,
   input  logic                       fire,
   input  logic [rmd_pkg::BYTE_W-1:0] item_byte,
   output rmd_pkg::result_type        result
);

   logic                       want_marker_ff, want_marker_in;
   logic                       want_id_ff, want_id_in;
   logic                       copying_ff, copying_in;
   logic                       last_ff, last_in;
   logic                       halted_ff, halted_in;
   logic [rmd_pkg::LEN_W-1:0]  pos_ff, pos_in;
   logic [rmd_pkg::LEN_W-1:0]  len_ff, len_in;
   logic [rmd_pkg::ID_W-1:0]   shift_ff, shift_in;
   logic [rmd_pkg::ID_W-1:0]   tid_ff, tid_in;
   logic [rmd_pkg::LEN_W-1:0]  copied_ff, copied_in;
   logic [rmd_pkg::LEN_W-1:0]  buf_ff;
   logic [rmd_pkg::LEN_W-1:0]  pos_inc;
   logic [rmd_pkg::LEN_W-1:0]  copied_inc;
   logic                       end_check;

   assign csr_ready  = 1'b1;
   assign pos_inc    = pos_ff + 31'd1;
   assign copied_inc = copied_ff + 31'd1;

   // Per-byte decode and next state
   always_comb begin
      want_marker_in = want_marker_ff;
      want_id_in     = want_id_ff;
      copying_in     = copying_ff;
      last_in        = last_ff;
      halted_in      = halted_ff;
      pos_in         = pos_ff;
      len_in         = len_ff;
      shift_in       = shift_ff;
      tid_in         = tid_ff;
      copied_in      = copied_ff;
      end_check      = 1'b0;

      result.out_byte     = item_byte;
      result.byte_kind    = rmd_pkg::KIND_DISCARD;
      result.reply_offset = '0;
      result.reply_done   = 1'b0;
      result.reply_length = '0;
      result.frame_error  = 1'b0;

      if (halted_ff) begin
         result.byte_kind = rmd_pkg::KIND_HALTED;
      end else if (want_marker_ff) begin
         result.byte_kind = rmd_pkg::KIND_MARKER;
         shift_in = {shift_ff[rmd_pkg::ID_W-rmd_pkg::BYTE_W-1:0], item_byte};
         pos_in   = pos_inc;
         if (pos_inc >= rmd_pkg::MARKER_BYTES) begin
            len_in         = shift_in[rmd_pkg::LEN_W-1:0];
            last_in        = shift_in[rmd_pkg::LAST_BIT];
            want_marker_in = 1'b0;
            pos_in         = '0;
            if (shift_in[rmd_pkg::LEN_W-1:0] < rmd_pkg::MIN_FRAG_LEN) begin
               result.frame_error = 1'b1;
               halted_in          = 1'b1;
            end
         end
      end else if (want_id_ff) begin
         result.byte_kind = rmd_pkg::KIND_ID;
         tid_in = {tid_ff[rmd_pkg::ID_W-rmd_pkg::BYTE_W-1:0], item_byte};
         pos_in = pos_inc;
         if (pos_inc >= rmd_pkg::ID_BYTES) begin
            want_id_in = 1'b0;
            copying_in = 1'b1;
            copied_in  = rmd_pkg::FIRST_OFFSET;
            end_check  = 1'b1;
         end
      end else if (copying_ff) begin
         if (copied_ff >= buf_ff) begin
            // buffer already full: drop and complete
            result.byte_kind    = rmd_pkg::KIND_DISCARD;
            copying_in          = 1'b0;
            result.reply_done   = 1'b1;
            result.reply_length = copied_ff;
         end else begin
            result.byte_kind    = rmd_pkg::KIND_PAYLOAD;
            result.reply_offset = copied_ff;
            copied_in           = copied_inc;
            if (copied_inc >= buf_ff || (pos_inc == len_ff && last_ff)) begin
               copying_in          = 1'b0;
               result.reply_done   = 1'b1;
               result.reply_length = copied_inc;
            end
         end
         pos_in    = pos_inc;
         end_check = 1'b1;
      end else begin
         pos_in    = pos_inc;
         end_check = 1'b1;
      end

      // End of fragment: next byte is a marker; last one closes the record
      if (end_check && pos_in == len_ff) begin
         want_marker_in = 1'b1;
         pos_in         = '0;
         if (last_ff) begin
            copying_in = 1'b0;
            want_id_in = 1'b1;
            copied_in  = '0;
         end
      end

      result.reply_id = tid_in;
   end

   // State registers, updated once per byte
   always_ff @(posedge clock) begin
      if (reset) begin
         want_marker_ff <= 1'b1;
         want_id_ff     <= 1'b1;
         copying_ff     <= 1'b0;
         last_ff        <= 1'b0;
         halted_ff      <= 1'b0;
         pos_ff         <= '0;
         len_ff         <= '0;
         shift_ff       <= '0;
         tid_ff         <= '0;
         copied_ff      <= '0;
      end else if (fire) begin
         want_marker_ff <= want_marker_in;
         want_id_ff     <= want_id_in;
         copying_ff     <= copying_in;
         last_ff        <= last_in;
         halted_ff      <= halted_in;
         pos_ff         <= pos_in;
         len_ff         <= len_in;
         shift_ff       <= shift_in;
         tid_ff         <= tid_in;
         copied_ff      <= copied_in;
      end
   end

   // Buffer size register
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff <= rmd_pkg::BUF_RESET;
      end else if (csr_valid && csr_ready) begin
         buf_ff <= csr_reply_buffer_bytes;
      end
   end

`ifndef ASSERT_OFF
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt state cleared without reset");

   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      (fire && result.frame_error) |=> halted_ff)
      else $error("frame error did not halt the deframer");

   a_marker_pos: assert property (@(posedge clock) disable iff (reset)
      (want_marker_ff && !halted_ff) |-> (pos_ff < rmd_pkg::MARKER_BYTES))
      else $error("marker byte count out of range");

   a_frag_pos: assert property (@(posedge clock) disable iff (reset)
      (!want_marker_ff && !halted_ff) |-> (pos_ff < len_ff))
      else $error("fragment position passed fragment length");

   a_copy_after_id: assert property (@(posedge clock) disable iff (reset)
      copying_ff |-> !want_id_ff)
      else $error("copying while transaction id still expected");
`endif

endmodule

@@ rtl/rmd_out_reg.sv @@
// Result register: holds one result until the response side takes it.
module rmd_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  rmd_pkg::result_type result,
   output logic                out_free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rmd_pkg::result_type rsp_item
);

   logic                valid_ff, valid_in;
   rmd_pkg::result_type item_ff, item_in;

   // Free when empty or when the held result leaves this cycle
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = fire || (valid_ff && !rsp_ready);
      item_in  = fire ? result : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

@@ tb/tb_rpc_record_marking_deframer.sv @@
// Self-checking testbench for the RPC record marking deframer.
`timescale 1ns / 100ps

// Tracks the record framing state and queues the expected result per request
class reply_tracker;
   logic [rmd_pkg::LEN_W-1:0] buffer_bytes;
   bit                        await_marker;
   bit                        await_xid;
   bit                        filling;
   bit                        final_fragment;
   bit                        stuck;
   logic [31:0]               frag_count;
   logic [rmd_pkg::LEN_W-1:0] frag_size;
   logic [31:0]               marker_acc;
   logic [31:0]               xid;
   logic [rmd_pkg::LEN_W-1:0] fill_level;
   rmd_pkg::result_type       queued_byte_results[$];
   int unsigned               mismatches;
   int unsigned               results_checked;
   int unsigned               replies_completed;

   function new();
      buffer_bytes      = rmd_pkg::BUF_RESET;
      await_marker      = 1'b1;
      await_xid         = 1'b1;
      filling           = 1'b0;
      final_fragment    = 1'b0;
      stuck             = 1'b0;
      frag_count        = '0;
      frag_size         = '0;
      marker_acc        = '0;
      xid               = '0;
      fill_level        = '0;
      mismatches        = 0;
      results_checked   = 0;
      replies_completed = 0;
   endfunction

   // Fragment exhausted: go back to the marker, and close the record on the last one
   function void close_fragment();
      if (frag_count == {1'b0, frag_size}) begin
         await_marker = 1'b1;
         frag_count   = '0;
         if (final_fragment) begin
            filling    = 1'b0;
            await_xid  = 1'b1;
            fill_level = '0;
         end
      end
   endfunction

   // Advance the framing state by one accepted request byte
   function void note_request(logic [rmd_pkg::BYTE_W-1:0] value);
      rmd_pkg::result_type r;
      r          = '0;
      r.out_byte = value;
      if (stuck) begin
         r.byte_kind = rmd_pkg::KIND_HALTED;
      end else if (await_marker) begin
         r.byte_kind = rmd_pkg::KIND_MARKER;
         marker_acc  = {marker_acc[23:0], value};
         frag_count  = frag_count + 32'd1;
         if (frag_count >= {1'b0, rmd_pkg::MARKER_BYTES}) begin
            frag_size      = marker_acc[rmd_pkg::LEN_W-1:0];
            final_fragment = marker_acc[rmd_pkg::LAST_BIT];
            await_marker   = 1'b0;
            frag_count     = '0;
            if (frag_size < rmd_pkg::MIN_FRAG_LEN) begin
               r.frame_error = 1'b1;
               stuck         = 1'b1;
            end
         end
      end else if (await_xid) begin
         r.byte_kind = rmd_pkg::KIND_ID;
         xid         = {xid[23:0], value};
         frag_count  = frag_count + 32'd1;
         if (frag_count >= {1'b0, rmd_pkg::ID_BYTES}) begin
            await_xid  = 1'b0;
            filling    = 1'b1;
            fill_level = rmd_pkg::FIRST_OFFSET;
            close_fragment();
         end
      end else if (filling) begin
         if (fill_level >= buffer_bytes) begin
            // buffer already full: drop the byte and finish the reply
            r.byte_kind    = rmd_pkg::KIND_DISCARD;
            filling        = 1'b0;
            r.reply_done   = 1'b1;
            r.reply_length = fill_level;
         end else begin
            r.byte_kind    = rmd_pkg::KIND_PAYLOAD;
            r.reply_offset = fill_level;
            fill_level     = fill_level + 1'b1;
            if (fill_level >= buffer_bytes ||
                (frag_count + 32'd1 == {1'b0, frag_size} && final_fragment)) begin
               filling        = 1'b0;
               r.reply_done   = 1'b1;
               r.reply_length = fill_level;
            end
         end
         frag_count = frag_count + 32'd1;
         close_fragment();
      end else begin
         r.byte_kind = rmd_pkg::KIND_DISCARD;
         frag_count  = frag_count + 32'd1;
         close_fragment();
      end
      r.reply_id = xid;
      queued_byte_results.push_back(r);
   endfunction

   task report(string msg);
      $display("MISMATCH %s", msg);
      mismatches++;
   endtask

   // Compare one observed result against the oldest queued one
   task check_result(rmd_pkg::result_type got);
      rmd_pkg::result_type exp;
      if (queued_byte_results.size() == 0) begin
         report($sformatf("unexpected result, byte %0h kind %0d",
                          got.out_byte, got.byte_kind));
         return;
      end
      exp = queued_byte_results.pop_front();
      results_checked++;
      if (got.out_byte !== exp.out_byte)
         report($sformatf("#%0d out_byte %0h, want %0h",
                          results_checked, got.out_byte, exp.out_byte));
      if (got.byte_kind !== exp.byte_kind)
         report($sformatf("#%0d byte_kind %0d, want %0d",
                          results_checked, got.byte_kind, exp.byte_kind));
      if (got.reply_offset !== exp.reply_offset)
         report($sformatf("#%0d reply_offset %0d, want %0d",
                          results_checked, got.reply_offset, exp.reply_offset));
      if (got.reply_id !== exp.reply_id)
         report($sformatf("#%0d reply_id %0h, want %0h",
                          results_checked, got.reply_id, exp.reply_id));
      if (got.reply_done !== exp.reply_done)
         report($sformatf("#%0d reply_done %0b, want %0b",
                          results_checked, got.reply_done, exp.reply_done));
      if (got.reply_length !== exp.reply_length)
         report($sformatf("#%0d reply_length %0d, want %0d",
                          results_checked, got.reply_length, exp.reply_length));
      if (got.frame_error !== exp.frame_error)
         report($sformatf("#%0d frame_error %0b, want %0b",
                          results_checked, got.frame_error, exp.frame_error));
      if (exp.reply_done)
         replies_completed++;
   endtask
endclass

module tb_rpc_record_marking_deframer;

   localparam int HOLD_OFF_CYCLES = 60;
   localparam int STALL_LIMIT     = 2000;
   localparam int PHASE_REQUESTS  = 205;
   localparam int SETTLE_CYCLES   = 6;

   // Two fragments (non-last of 5, last of 4), then a record with only an id
   localparam logic [7:0] OPENING_BYTES [25] = '{
      8'h00, 8'h00, 8'h00, 8'h05, 8'h00, 8'hff, 8'h12, 8'h34, 8'hff,
      8'h80, 8'h00, 8'h00, 8'h04, 8'h00, 8'haa, 8'h55, 8'hff,
      8'h80, 8'h00, 8'h00, 8'h04, 8'hde, 8'had, 8'hbe, 8'hef
   };

   // Buffer sizes for the random phases; the last phase picks one at random
   localparam logic [rmd_pkg::LEN_W-1:0] BUFFER_SIZES [5] = '{
      31'd4, 31'h7fffffff, 31'd9, 31'd5, 31'd30
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [rmd_pkg::BYTE_W-1:0] req_byte_value = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [rmd_pkg::BYTE_W-1:0] rsp_out_byte;
   logic [2:0]                 rsp_byte_kind;
   logic [rmd_pkg::LEN_W-1:0]  rsp_reply_offset;
   logic [rmd_pkg::ID_W-1:0]   rsp_reply_id;
   logic                       rsp_reply_done;
   logic [rmd_pkg::LEN_W-1:0]  rsp_reply_length;
   logic                       rsp_frame_error;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [rmd_pkg::LEN_W-1:0]  csr_reply_buffer_bytes = rmd_pkg::BUF_RESET;

   reply_tracker        tracker = new();
   rmd_pkg::result_type seen;

   int unsigned send_idle_pct = 6;
   int unsigned recv_idle_pct = 79;
   int          hold_left = 0;
   logic        hold_off_pending = 1'b0;
   bit          hold_off_done = 1'b0;
   int          requests_sent = 0;
   int          quiet_cycles = 0;

   rpc_record_marking_deframer u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_byte_value         (req_byte_value),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_out_byte           (rsp_out_byte),
      .rsp_byte_kind          (rsp_byte_kind),
      .rsp_reply_offset       (rsp_reply_offset),
      .rsp_reply_id           (rsp_reply_id),
      .rsp_reply_done         (rsp_reply_done),
      .rsp_reply_length       (rsp_reply_length),
      .rsp_frame_error        (rsp_frame_error),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_reply_buffer_bytes (csr_reply_buffer_bytes)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: random back-pressure, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_off_pending) begin
         hold_off_pending <= 1'b0;
         hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Check every accepted result
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen.out_byte     = rsp_out_byte;
         seen.byte_kind    = rmd_pkg::kind_type'(rsp_byte_kind);
         seen.reply_offset = rsp_reply_offset;
         seen.reply_id     = rsp_reply_id;
         seen.reply_done   = rsp_reply_done;
         seen.reply_length = rsp_reply_length;
         seen.frame_error  = rsp_frame_error;
         tracker.check_result(seen);
      end
   end

   // Watchdog: no handshake of any kind for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Offer one request byte; starts and ends at a falling edge, valid left high
   task automatic send_byte(input logic [rmd_pkg::BYTE_W-1:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_byte_value = value;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      tracker.note_request(value);
      requests_sent++;
      @(negedge clock);
   endtask

   // Stop offering and wait until every queued result has come back
   task automatic wait_for_drain();
      req_valid = 1'b0;
      while (tracker.queued_byte_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_buffer_size(input logic [rmd_pkg::LEN_W-1:0] value);
      wait_for_drain();
      csr_valid              = 1'b1;
      csr_reply_buffer_bytes = value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      tracker.buffer_bytes = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // One well-formed record of one to three fragments with random content
   task automatic send_record();
      int                        frags;
      int                        pick;
      logic [rmd_pkg::LEN_W-1:0] len;
      logic [31:0]               marker;
      frags = ($urandom_range(0, 99) < 70) ? 1 : int'($urandom_range(2, 3));
      for (int f = 0; f < frags; f++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8)
            len = rmd_pkg::MIN_FRAG_LEN;
         else if (pick < 80)
            len = 31'($urandom_range(5, 24));
         else if (pick < 97)
            len = 31'($urandom_range(25, 120));
         else
            len = 31'($urandom_range(121, 700));
         marker = {f == frags - 1, len};
         for (int k = 3; k >= 0; k--)
            send_byte(marker[8*k +: 8]);
         repeat (len) send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int                        phase_start;
      logic [rmd_pkg::LEN_W-1:0] size;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed opening at the reset buffer size
      foreach (OPENING_BYTES[i])
         send_byte(OPENING_BYTES[i]);

      // Random records: sender-light idling, then receiver-light, then none
      for (int phase = 0; phase < 6; phase++) begin
         size = (phase < 5) ? BUFFER_SIZES[phase] : 31'($urandom_range(4, 64));
         write_buffer_size(size);
         send_idle_pct = (phase < 2) ? 6 : (phase < 4) ? 79 : 0;
         recv_idle_pct <= (phase < 2) ? 79 : (phase < 4) ? 6 : 0;
         phase_start = requests_sent;
         while (requests_sent - phase_start < PHASE_REQUESTS) begin
            if (phase == 4 && !hold_off_done && requests_sent - phase_start > 30) begin
               hold_off_pending <= 1'b1;
               hold_off_done = 1'b1;
            end
            send_record();
         end
      end

      // Short fragment marker, then bytes that the halted block only echoes
      send_byte($urandom_range(0, 1) ? 8'h80 : 8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'($urandom_range(0, 3)));
      repeat (6) send_byte(8'($urandom_range(0, 255)));

      wait_for_drain();
      $display("Sent %0d request bytes, checked %0d results, %0d replies completed",
               requests_sent, tracker.results_checked, tracker.replies_completed);
      $display("Buffer sizes 4 up to 2^31-1, mixed stalls, a long hold-off, framing halt");
      if (tracker.mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

@@ rpc_record_marking_deframer.f @@
rtl/rmd_pkg.sv
rtl/rmd_in_reg.sv
rtl/rmd_core.sv
rtl/rmd_out_reg.sv
rtl/rpc_record_marking_deframer.sv
tb/tb_rpc_record_marking_deframer.sv
